/* rtl/w_pbt_pkg.sv */
// ---------------------------------------------------------------------------
// w_pbt_pkg
// Types, widths and constants of the W' balance tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package w_pbt_pkg;

  // field widths of the stream and register interfaces
  localparam int WATTS_W    = 12;
  localparam int CP_W       = 12;
  localparam int WP_W       = 17;
  localparam int GAIN_W     = 16;
  localparam int DEC_W      = 16;
  localparam int EXH_W      = 17;
  localparam int OUT_W      = 21;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 48;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;
  localparam int APB_W      = 32;

  // internal datapath widths
  localparam int SUM_W      = 70;   // shared adder
  localparam int ACC_W      = 40;   // balance and excess state
  localparam int NUM_W      = 52;   // |W'q - bal| * (CP - watts)
  localparam int MAG_W      = NUM_W;
  localparam int MPL_W      = 16;   // serial multiplier operand
  localparam int P_W        = 68;   // num * gain
  localparam int QUO_W      = 56;   // quotient bits of (num * gain) / W'
  localparam int GAIN_FRAC  = 8;    // gain is Q8.8
  localparam int T_W        = QUO_W - GAIN_FRAC;
  localparam int REM_W      = WP_W;
  localparam int CNT_W      = 6;

  // step counts of the serial loops
  localparam int NUM_STEPS  = CP_W;
  localparam int GAIN_STEPS = GAIN_W;
  localparam int DEC_STEPS  = DEC_W;
  localparam int DIV_STEPS  = QUO_W;

  // register reset values
  localparam logic              RST_MODE  = 1'b1;
  localparam logic [CP_W-1:0]   RST_CP    = 12'd250;
  localparam logic [WP_W-1:0]   RST_WP    = 17'd20000;
  localparam logic [GAIN_W-1:0] RST_GAIN  = 16'd128;
  localparam logic [DEC_W-1:0]  RST_DECAY = 16'd65389;
  localparam logic [EXH_W-1:0]  RST_EXH   = 17'd500;

  // register map, one 32-bit word each
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE,
    REG_CP,
    REG_WPRIME,
    REG_GAIN,
    REG_DECAY,
    REG_EXH
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DEC,
    ST_INT_ADD,
    ST_INT_BAL,
    ST_REC_DIFF,
    ST_REC_ABS,
    ST_MUL_NUM,
    ST_REC_CHK,
    ST_MUL_GAIN,
    ST_DIV,
    ST_REC_BAL,
    ST_DRAIN,
    ST_MARGIN
  } state_t;

  // clamp a signed adder result to the 40-bit signed balance range
  function automatic logic [ACC_W-1:0] sat_acc(input logic [SUM_W-1:0] v);
    logic [SUM_W-ACC_W:0] top;
    top = v[SUM_W-1:ACC_W-1];
    if ((&top) || (~|top)) begin
      return v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  // clamp a non-negative adder result to the 40-bit unsigned excess range
  function automatic logic [ACC_W-1:0] sat_exc(input logic [SUM_W-1:0] v);
    if (|v[SUM_W-1:ACC_W]) begin
      return {ACC_W{1'b1}};
    end else begin
      return v[ACC_W-1:0];
    end
  endfunction

  // clamp a signed value to the 21-bit signed result range
  function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_W-1:0] v);
    logic [SUM_W-OUT_W:0] top;
    top = v[SUM_W-1:OUT_W-1];
    if ((&top) || (~|top)) begin
      return v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/w_prime_balance_tracker_core.sv */
// ---------------------------------------------------------------------------
// w_prime_balance_tracker_core
// Anaerobic work balance tracker, one result per one-second power sample.
// ---------------------------------------------------------------------------
// The block takes one power sample per transfer and returns the W' balance
// and its margin above the exhaustion level, both in whole joules and
// saturated to 21 bits signed. All arithmetic runs through one shared 70-bit
// adder under a small sequencer: multiplies are shift-add, one multiplier bit
// per cycle, and the divide by W' is restoring, one quotient bit per cycle.
// Integral mode runs the decay multiply, excess add and balance update;
// differential mode drains at or above CP, else forms |W'-bal|*(CP-watts),
// then the gain multiply and the divide, both skipped when the recovery
// term saturates. s_tready is high again in the cycle after the result is
// loaded into the output register; the next sample may then be accepted
// while that result still waits on m_tready. A full output register holds
// the sequencer in its last step. The user must write registers through
// the APB port only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module w_prime_balance_tracker_core
  import w_pbt_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst,
  // input stream
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire  [S_TDATA_W-1:0]   s_tdata,   // [11:0] watts, [15:12] zero
  input  wire                    s_tlast,   // last_sample
  // result stream
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // [20:0] balance, [41:21] margin,
                                            // [47:42] zero
  output logic                   m_tlast,   // series_end
  // register port
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [ADDR_W-1:0]      paddr,
  input  wire  [APB_W-1:0]       pwdata,
  output logic [APB_W-1:0]       prdata,
  output logic                   pready
);

  // configuration registers
  logic              mode_integral;
  logic [CP_W-1:0]   critical_power;
  logic [WP_W-1:0]   wprime;
  logic [GAIN_W-1:0] recovery_gain;
  logic [DEC_W-1:0]  decay_factor;
  logic [EXH_W-1:0]  exhaustion_level;

  // tracker state
  logic [ACC_W-1:0]  balance_acc;
  logic [ACC_W-1:0]  decayed_excess;

  // sequencer and working registers
  state_t            state;
  state_t            state_next;
  logic [SUM_W-1:0]  work;
  logic [MAG_W-1:0]  mcand;
  logic [MPL_W-1:0]  mplier;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic              neg;
  logic              last_q;
  logic [WATTS_W-1:0] watts_q;

  // shared adder
  logic [SUM_W-1:0]  add_a;
  logic [SUM_W-1:0]  add_b;
  logic              add_sub;
  logic [SUM_W-1:0]  add_sum;

  // derived values
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              s_xfer;
  logic              out_free;
  logic              commit;
  logic [WATTS_W-1:0] s_watts;
  logic [WP_W-1:0]   w_eff;
  logic [SUM_W-1:0]  wq_ext;
  logic [SUM_W-1:0]  bal_ext;
  logic [ACC_W-1:0]  whole;
  logic [SUM_W-1:0]  whole_ext;
  logic [CP_W-1:0]   ex_w;
  logic [CP_W-1:0]   dcp;
  logic [SUM_W-1:0]  ex_shift;
  logic [T_W-1:0]    t_val;
  logic              qbit;
  logic              loop_done;

  // handshakes
  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == ST_MARGIN) && out_free;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready   = 1'b1;
  assign s_watts  = s_tdata[WATTS_W-1:0];

  // operand preparation
  assign w_eff     = (wprime == '0) ? WP_W'(1) : wprime;
  assign wq_ext    = SUM_W'(w_eff) << FRAC_BITS;
  assign bal_ext   = {{(SUM_W-ACC_W){balance_acc[ACC_W-1]}}, balance_acc};
  assign whole     = ACC_W'($signed(balance_acc) >>> FRAC_BITS);
  assign whole_ext = {{(SUM_W-ACC_W){whole[ACC_W-1]}}, whole};
  assign ex_w      = (watts_q > critical_power) ? (watts_q - critical_power) : '0;
  assign dcp       = (watts_q < critical_power) ? (critical_power - watts_q) : '0;
  assign ex_shift  = SUM_W'(ex_w) << FRAC_BITS;
  assign t_val     = ovf ? (T_W'(1) << ACC_W) : work[QUO_W-1:GAIN_FRAC];
  assign loop_done = (cnt == CNT_W'(1));

  // shared add/subtract unit
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);
  assign qbit    = ~add_sum[SUM_W-1];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          if (mode_integral) begin
            state_next = ST_MUL_DEC;
          end else if (s_watts < critical_power) begin
            state_next = ST_REC_DIFF;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_MUL_DEC:  if (loop_done) state_next = ST_INT_ADD;
      ST_INT_ADD:  state_next = ST_INT_BAL;
      ST_INT_BAL:  state_next = ST_MARGIN;
      ST_REC_DIFF: state_next = ST_REC_ABS;
      ST_REC_ABS:  state_next = ST_MUL_NUM;
      ST_MUL_NUM:  if (loop_done) state_next = ST_REC_CHK;
      ST_REC_CHK:  state_next = qbit ? ST_REC_BAL : ST_MUL_GAIN;
      ST_MUL_GAIN: if (loop_done) state_next = ST_DIV;
      ST_DIV:      if (loop_done) state_next = ST_REC_BAL;
      ST_REC_BAL:  state_next = ST_MARGIN;
      ST_DRAIN:    state_next = ST_MARGIN;
      ST_MARGIN:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // adder operand selection per step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      ST_MUL_DEC, ST_MUL_NUM, ST_MUL_GAIN: begin
        add_a = {work[SUM_W-2:0], 1'b0};
        add_b = mplier[MPL_W-1] ? SUM_W'(mcand) : '0;
      end
      ST_INT_ADD: begin
        add_a = SUM_W'(work[ACC_W+DEC_W-1:DEC_W]);
        add_b = ex_shift;
      end
      ST_INT_BAL: begin
        add_a   = wq_ext;
        add_b   = SUM_W'(decayed_excess);
        add_sub = 1'b1;
      end
      ST_REC_DIFF: begin
        add_a   = wq_ext;
        add_b   = bal_ext;
        add_sub = 1'b1;
      end
      ST_REC_ABS: begin
        add_b   = work;
        add_sub = work[SUM_W-1];
      end
      ST_REC_CHK: begin
        add_a   = SUM_W'(work[NUM_W-1:ACC_W]);
        add_b   = SUM_W'(w_eff);
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = SUM_W'({rem, work[QUO_W-1]});
        add_b   = SUM_W'(w_eff);
        add_sub = 1'b1;
      end
      ST_REC_BAL: begin
        add_a   = bal_ext;
        add_b   = SUM_W'(t_val);
        add_sub = neg;
      end
      ST_DRAIN: begin
        add_a   = bal_ext;
        add_b   = ex_shift;
        add_sub = 1'b1;
      end
      ST_MARGIN: begin
        add_a   = whole_ext;
        add_b   = SUM_W'(exhaustion_level);
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
      end
    endcase
  end

  // control state, registers and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      mode_integral    <= RST_MODE;
      critical_power   <= RST_CP;
      wprime           <= RST_WP;
      recovery_gain    <= RST_GAIN;
      decay_factor     <= RST_DECAY;
      exhaustion_level <= RST_EXH;
      balance_acc      <= ACC_W'(RST_WP) << FRAC_BITS;
      decayed_excess   <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MODE:   mode_integral    <= pwdata[0];
          REG_CP:     critical_power   <= pwdata[CP_W-1:0];
          REG_WPRIME: wprime           <= pwdata[WP_W-1:0];
          REG_GAIN:   recovery_gain    <= pwdata[GAIN_W-1:0];
          REG_DECAY:  decay_factor     <= pwdata[DEC_W-1:0];
          REG_EXH:    exhaustion_level <= pwdata[EXH_W-1:0];
          default:    mode_integral    <= mode_integral;
        endcase
      end

      // state updates from the adder
      if (state == ST_INT_ADD) begin
        decayed_excess <= sat_exc(add_sum);
      end
      if ((state == ST_INT_BAL) || (state == ST_REC_BAL) || (state == ST_DRAIN)) begin
        balance_acc <= sat_acc(add_sum);
      end

      // series end reloads after the result is taken into the output register
      if (commit && last_q) begin
        balance_acc    <= ACC_W'(wprime) << FRAC_BITS;
        decayed_excess <= '0;
      end

      // output register occupancy
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers of the serial loops
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          watts_q <= s_watts;
          last_q  <= s_tlast;
          work    <= '0;
          mcand   <= MAG_W'(decayed_excess);
          mplier  <= decay_factor;
          cnt     <= CNT_W'(DEC_STEPS);
        end
      end
      ST_MUL_DEC, ST_MUL_NUM: begin
        work   <= add_sum;
        mplier <= mplier << 1;
        cnt    <= cnt - CNT_W'(1);
      end
      ST_MUL_GAIN: begin
        mplier <= mplier << 1;
        if (loop_done) begin
          // product complete: split into starting remainder and dividend bits
          rem  <= REM_W'(add_sum[P_W-1:QUO_W]);
          work <= SUM_W'(add_sum[QUO_W-1:0]);
          cnt  <= CNT_W'(DIV_STEPS);
        end else begin
          work <= add_sum;
          cnt  <= cnt - CNT_W'(1);
        end
      end
      ST_REC_DIFF: begin
        work <= add_sum;
      end
      ST_REC_ABS: begin
        neg    <= work[SUM_W-1];
        mcand  <= add_sum[MAG_W-1:0];
        work   <= '0;
        mplier <= MPL_W'(dcp) << (MPL_W - CP_W);
        cnt    <= CNT_W'(NUM_STEPS);
      end
      ST_REC_CHK: begin
        // quotient would reach 2^40 when num / 2^40 >= W'
        ovf    <= qbit;
        mcand  <= work[MAG_W-1:0];
        work   <= '0;
        mplier <= recovery_gain;
        cnt    <= CNT_W'(GAIN_STEPS);
      end
      ST_DIV: begin
        rem  <= qbit ? add_sum[REM_W-1:0] : {rem[REM_W-2:0], work[QUO_W-1]};
        work <= SUM_W'({work[QUO_W-2:0], qbit});
        cnt  <= cnt - CNT_W'(1);
      end
      ST_MARGIN: begin
        if (out_free) begin
          m_tdata <= {{(M_TDATA_W-2*OUT_W){1'b0}}, sat_out(add_sum), sat_out(whole_ext)};
          m_tlast <= last_q;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MODE:   prdata = APB_W'(mode_integral);
      REG_CP:     prdata = APB_W'(critical_power);
      REG_WPRIME: prdata = APB_W'(wprime);
      REG_GAIN:   prdata = APB_W'(recovery_gain);
      REG_DECAY:  prdata = APB_W'(decay_factor);
      REG_EXH:    prdata = APB_W'(exhaustion_level);
      default:    prdata = '0;
    endcase
  end

  // a new result only ever comes from the final step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_MARGIN)
    else $error("result register loaded outside the final step");

  // series end clears the excess sum
  a_series_reload: assert property (@(posedge clk) disable iff (rst)
    (commit && last_q) |=> decayed_excess == '0)
    else $error("excess sum not cleared after series end");

  // loop counters never run out inside a loop
  a_loop_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_DEC || state == ST_MUL_NUM || state == ST_MUL_GAIN ||
     state == ST_DIV) |-> cnt != '0)
    else $error("serial loop counter underflow");

  // the recovery update follows the divide or a saturated quotient only
  a_rec_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REC_BAL) |-> ($past(state) == ST_DIV || $past(state) == ST_REC_CHK))
    else $error("recovery update entered from an unexpected step");

endmodule

`default_nettype wire

/* test/w_pbt_checker.sv */
// ---------------------------------------------------------------------------
// w_pbt_checker
// Result checker of the W' balance tracker: follows the register port and
// the sample stream, works out the balance and margin that every accepted
// sample should give, and compares them with the result stream in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module w_pbt_checker
  import w_pbt_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  input  wire                  s_tready,
  input  wire [S_TDATA_W-1:0]  s_tdata,   // [11:0] watts, [15:12] zero
  input  wire                  s_tlast,   // last_sample
  input  wire                  m_tvalid,
  input  wire                  m_tready,
  input  wire [M_TDATA_W-1:0]  m_tdata,   // [20:0] balance, [41:21] margin,
                                          // [47:42] zero
  input  wire                  m_tlast,   // series_end
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire                  pready,
  input  wire [ADDR_W-1:0]     paddr,
  input  wire [APB_W-1:0]      pwdata,
  output int                   mismatches,
  output int                   results_owed
);

  localparam int              FRAC       = 8;
  localparam int              REPORT_MAX = 10;
  localparam longint          ACC_HI     = 64'sh0000_007F_FFFF_FFFF;
  localparam longint          ACC_LO     = -64'sh0000_0080_0000_0000;
  localparam longint unsigned EXC_HI     = 64'h0000_00FF_FFFF_FFFF;
  localparam longint          OUT_HI     = 1048575;
  localparam longint          OUT_LO     = -1048576;

  typedef struct packed {
    logic [OUT_W-1:0] balance;
    logic [OUT_W-1:0] margin;
    logic             series_end;
  } result_t;

  // shadow copy of the register file
  logic              mode_int;
  logic [CP_W-1:0]   cp;
  logic [WP_W-1:0]   wp;
  logic [GAIN_W-1:0] gain;
  logic [DEC_W-1:0]  decay;
  logic [EXH_W-1:0]  exh;

  // tracked state: signed balance and unsigned decayed excess, both Q.8
  longint            bal_acc;
  longint unsigned   excess;

  result_t           pending_results[$];
  result_t           got;
  result_t           want;

  initial mismatches = 0;
  initial results_owed = 0;

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input longint v);
    longint c;
    c = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
    return c[OUT_W-1:0];
  endfunction

  // advance the tracked state by one sample and form its result
  function automatic result_t next_balance(input logic [WATTS_W-1:0] watts,
                                           input logic last);
    longint unsigned w;
    longint unsigned c;
    longint unsigned w_eff;
    longint unsigned ex;
    longint unsigned d;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    longint unsigned t;
    longint          wq;
    longint          diff;
    longint          whole;
    result_t         res;
    w = watts;
    c = cp;
    // a zero capacity counts as one joule
    w_eff = (wp == '0) ? 1 : wp;
    wq = longint'(w_eff << FRAC);
    if (mode_int) begin
      // integral: decay the excess sum, add this second's excess
      ex = (w > c) ? (w - c) : 0;
      d = ((excess * decay) >> DEC_W) + (ex << FRAC);
      if (d > EXC_HI) d = EXC_HI;
      excess = d;
      bal_acc = clamp_acc(wq - longint'(d));
    end else if (w < c) begin
      // differential recovery toward W', exact floor of the scaled ratio
      diff = wq - bal_acc;
      mag = (diff < 0) ? -diff : diff;
      num = mag * (c - w);
      q = num / w_eff;
      r = num % w_eff;
      if (q > EXC_HI) begin
        t = EXC_HI + 1;
      end else begin
        t = (q * gain + (r * gain) / w_eff) >> GAIN_FRAC;
      end
      bal_acc = clamp_acc((diff < 0) ? bal_acc - longint'(t) : bal_acc + longint'(t));
    end else begin
      // differential drain at or above CP
      bal_acc = clamp_acc(bal_acc - longint'((w - c) << FRAC));
    end
    whole = bal_acc >>> FRAC;
    res.balance = clamp_out(whole);
    res.margin = clamp_out(whole - longint'(exh));
    res.series_end = last;
    // series end reloads from the raw capacity
    if (last) begin
      bal_acc = longint'(wp) << FRAC;
      excess = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_int = RST_MODE;
      cp = RST_CP;
      wp = RST_WP;
      gain = RST_GAIN;
      decay = RST_DECAY;
      exh = RST_EXH;
      bal_acc = longint'(RST_WP) << FRAC;
      excess = 0;
      pending_results.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MODE:   mode_int = pwdata[0];
          REG_CP:     cp = pwdata[CP_W-1:0];
          REG_WPRIME: wp = pwdata[WP_W-1:0];
          REG_GAIN:   gain = pwdata[GAIN_W-1:0];
          REG_DECAY:  decay = pwdata[DEC_W-1:0];
          REG_EXH:    exh = pwdata[EXH_W-1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.balance = m_tdata[OUT_W-1:0];
        got.margin = m_tdata[2*OUT_W-1:OUT_W];
        got.series_end = m_tlast;
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%m: unexpected result at %0t: balance %0d margin %0d end %0b",
                     $time, $signed(got.balance), $signed(got.margin), got.series_end);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.balance !== want.balance || got.margin !== want.margin ||
              got.series_end !== want.series_end) begin
            if (mismatches < REPORT_MAX) begin
              $display("%m: mismatch at %0t: balance exp %0d got %0d, margin exp %0d got %0d, end exp %0b got %0b",
                       $time, $signed(want.balance), $signed(got.balance),
                       $signed(want.margin), $signed(got.margin),
                       want.series_end, got.series_end);
            end
            mismatches++;
          end
        end
      end
      // sample transfer
      if (s_tvalid && s_tready) begin
        pending_results.push_back(next_balance(s_tdata[WATTS_W-1:0], s_tlast));
      end
    end
    results_owed = pending_results.size();
  end

endmodule

/* test/tb_w_prime_balance_tracker_core.sv */
// ---------------------------------------------------------------------------
// tb_w_prime_balance_tracker_core
// Testbench of the W' balance tracker core.
// ---------------------------------------------------------------------------
// Drives power samples in bursts with random gaps and stalls the result
// stream on changing patterns. A directed part walks both models, equal and
// crossing CP, register extremes, zero capacity and mode switches inside a
// series; a long drain and the recovery after it push the balance into
// saturation both ways; random series with register changes between them
// follow. Registers are only written once every result is back. The
// checker beside the core does all prediction and comparison.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_w_prime_balance_tracker_core;
  import w_pbt_pkg::*;

  localparam int WATTS_MAX       = (1 << WATTS_W) - 1;
  localparam int RANDOM_SAMPLES  = 330;
  localparam int DRAIN_SAMPLES   = 280;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 100;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [APB_W-1:0]      pwdata = '0;
  logic [APB_W-1:0]      prdata;
  logic                  pready;

  int                    mismatches;
  int                    results_owed;

  int                    burst_left = 0;
  int                    gap;
  int                    idle_cycles = 0;
  int                    samples_sent = 0;
  int                    series_len;
  logic [CP_W-1:0]       cur_cp = RST_CP;

  rx_mode_t              rx_mode = RX_OPEN;
  int                    rx_left = 0;
  logic [7:0]            rx_pat = 8'hff;

  always #4 clk = ~clk;

  w_prime_balance_tracker_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  w_pbt_checker result_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // result side back-pressure, with a pattern that switches at random
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
      rx_pat <= 8'($urandom_range(1, 255));
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= rx_pat[rx_left % 8];
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_w_prime_balance_tracker_core: FAIL");
      $finish;
    end
  end

  // one sample transfer, then the burst and gap pacing
  task automatic send_sample(input int watts, input logic last);
    s_tdata <= {{(S_TDATA_W-WATTS_W){1'b0}}, watts[WATTS_W-1:0]};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  // stop sending and wait for every owed result
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // register write: setup then access; psel stays up for back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    if (idx == REG_CP) cur_cp = value[CP_W-1:0];
  endtask

  task automatic release_bus();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // extremes now and then, else mostly a typical band
  function automatic int unsigned pick_reg(input int unsigned lo, input int unsigned hi,
                                           input int unsigned typ_lo, input int unsigned typ_hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      2, 3:    return $urandom_range(lo, hi);
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  function automatic int pick_watts();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = WATTS_MAX;
      2, 3:    v = int'(cur_cp) - 30 + int'($urandom_range(0, 60));
      4, 5, 6: v = $urandom_range(0, WATTS_MAX);
      default: v = $urandom_range(0, 700);
    endcase
    if (v < 0) v = 0;
    if (v > WATTS_MAX) v = WATTS_MAX;
    return v;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // integral model at reset settings: idle, max, equal to CP, just above
    send_sample(0, 1'b0);
    send_sample(WATTS_MAX, 1'b0);
    send_sample(250, 1'b0);
    send_sample(251, 1'b0);
    send_sample(WATTS_MAX, 1'b1);
    wait_results();

    // slowest decay, highest CP and exhaustion level
    write_reg(REG_DECAY, 65535);
    write_reg(REG_EXH, 131071);
    write_reg(REG_CP, WATTS_MAX);
    release_bus();
    send_sample(WATTS_MAX, 1'b0);
    send_sample(0, 1'b1);
    wait_results();

    // no decay memory, zero CP, largest capacity, zero exhaustion level
    write_reg(REG_DECAY, 0);
    write_reg(REG_CP, 0);
    write_reg(REG_EXH, 0);
    write_reg(REG_WPRIME, 131071);
    release_bus();
    send_sample(WATTS_MAX, 1'b0);
    send_sample(WATTS_MAX, 1'b0);
    send_sample(1, 1'b1);
    wait_results();

    // differential model: drain, equal to CP, recovery
    write_reg(REG_MODE, 0);
    write_reg(REG_CP, 250);
    write_reg(REG_WPRIME, 20000);
    write_reg(REG_GAIN, 128);
    write_reg(REG_EXH, 500);
    release_bus();
    send_sample(WATTS_MAX, 1'b0);
    send_sample(400, 1'b0);
    send_sample(250, 1'b0);
    send_sample(0, 1'b0);
    send_sample(100, 1'b0);
    wait_results();

    // capacity shrinks inside the series: recovery from above W'
    write_reg(REG_WPRIME, 1);
    write_reg(REG_GAIN, 65535);
    release_bus();
    send_sample(0, 1'b0);
    send_sample(249, 1'b0);
    send_sample(0, 1'b1);
    wait_results();

    // zero gain and zero capacity
    write_reg(REG_GAIN, 0);
    write_reg(REG_WPRIME, 0);
    release_bus();
    send_sample(0, 1'b0);
    send_sample(100, 1'b0);
    wait_results();

    // mode switches inside one series
    write_reg(REG_MODE, 1);
    write_reg(REG_DECAY, 65389);
    release_bus();
    send_sample(300, 1'b0);
    wait_results();
    write_reg(REG_MODE, 0);
    write_reg(REG_GAIN, 128);
    release_bus();
    send_sample(0, 1'b1);
    wait_results();

    // long drain with unit capacity, then recovery past both balance limits
    write_reg(REG_MODE, 0);
    write_reg(REG_CP, 0);
    write_reg(REG_WPRIME, 0);
    write_reg(REG_GAIN, 65535);
    release_bus();
    repeat (DRAIN_SAMPLES) send_sample(WATTS_MAX, 1'b0);
    wait_results();
    write_reg(REG_CP, WATTS_MAX);
    release_bus();
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(WATTS_MAX, 1'b1);
    wait_results();

    // random series with register changes between them
    while (samples_sent < RANDOM_SAMPLES) begin
      wait_results();
      if ($urandom_range(0, 2) == 0) write_reg(REG_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) write_reg(REG_CP, pick_reg(0, WATTS_MAX, 100, 450));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_WPRIME, ($urandom_range(0, 15) == 0) ? 0 : pick_reg(1, 131071, 5000, 40000));
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_GAIN, pick_reg(0, 65535, 16, 1024));
      if ($urandom_range(0, 2) == 0) write_reg(REG_DECAY, pick_reg(0, 65535, 60000, 65535));
      if ($urandom_range(0, 2) == 0) write_reg(REG_EXH, pick_reg(0, 131071, 0, 5000));
      release_bus();
      series_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      for (int i = 0; i < series_len; i++) begin
        if (i == series_len - 1) begin
          send_sample(pick_watts(), $urandom_range(0, 3) != 0);
        end else begin
          send_sample(pick_watts(), $urandom_range(0, 31) == 0);
        end
        samples_sent++;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_w_prime_balance_tracker_core: PASS");
    end else begin
      $display("tb_w_prime_balance_tracker_core: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/w_pbt_pkg.sv
rtl/w_prime_balance_tracker_core.sv
test/w_pbt_checker.sv
test/tb_w_prime_balance_tracker_core.sv
